FILE: sv/rvcq1_pkg.sv
// Shared definitions for the RV32C quadrant-1 expander.
// Holds the opcode and function codes and the decode result type; no dependencies.
`timescale 1ns / 1ps

package rvcq1_pkg;

  // Compressed quadrant and funct3 codes of quadrant 1.
  localparam logic [1:0] QUADRANT1 = 2'b01;
  localparam logic [2:0] C3_ADDI   = 3'b000;
  localparam logic [2:0] C3_LI     = 3'b010;
  localparam logic [2:0] C3_LUI    = 3'b011;
  localparam logic [2:0] C3_ALU    = 3'b100;

  // funct2 codes of the arithmetic group, bits [11:10].
  localparam logic [1:0] F2_SRLI = 2'b00;
  localparam logic [1:0] F2_SRAI = 2'b01;
  localparam logic [1:0] F2_ANDI = 2'b10;
  localparam logic [1:0] F2_REG  = 2'b11;

  // Register-register selector, bits [6:5].
  localparam logic [1:0] SEL_SUB = 2'b00;
  localparam logic [1:0] SEL_XOR = 2'b01;
  localparam logic [1:0] SEL_OR  = 2'b10;
  localparam logic [1:0] SEL_AND = 2'b11;

  // RV32I encoding fields.
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] FUNCT7_ALT = 7'h20;
  localparam logic [6:0] FUNCT7_STD = 7'h00;
  localparam logic [2:0] F3_ADD     = 3'b000;
  localparam logic [2:0] F3_XOR     = 3'b100;
  localparam logic [2:0] F3_SR      = 3'b101;
  localparam logic [2:0] F3_OR      = 3'b110;
  localparam logic [2:0] F3_AND     = 3'b111;
  localparam logic [4:0] REG_ZERO   = 5'd0;
  localparam logic [4:0] REG_SP     = 5'd2;

  typedef struct packed {
    logic [31:0] word;
    logic        illegal;
  } expand_result_t;

endpackage

FILE: sv/rvcq1_decoder.sv
// Combinational expansion of one quadrant-1 compressed halfword to RV32I.
// Depends on rvcq1_pkg for the encoding constants and the result type.
`timescale 1ns / 1ps

module rvcq1_decoder import rvcq1_pkg::*; (
  input  logic [15:0]    cinstr,
  output expand_result_t result
);

  logic [2:0]  funct3;
  logic [1:0]  funct2;
  logic [1:0]  sel;
  logic [4:0]  rd;
  logic [4:0]  rdp;
  logic [4:0]  rs2p;
  logic [4:0]  low5;
  logic [11:0] imm6;
  logic [11:0] imm16sp;
  logic [19:0] imm_lui;
  logic [31:0] word;
  logic        bad;

  assign funct3 = cinstr[15:13];
  assign funct2 = cinstr[11:10];
  assign sel    = cinstr[6:5];
  assign rd     = cinstr[11:7];
  assign rdp    = {2'b01, cinstr[9:7]};
  assign rs2p   = {2'b01, cinstr[4:2]};
  assign low5   = cinstr[6:2];
  assign imm6   = {{6{cinstr[12]}}, cinstr[12], low5};
  assign imm16sp = {{3{cinstr[12]}}, cinstr[4:3], cinstr[5],
                    cinstr[2], cinstr[6], 4'b0000};
  assign imm_lui = {{14{cinstr[12]}}, cinstr[12], low5};

  always_comb begin
    word = '0;
    bad  = 1'b0;
    if (cinstr[1:0] != QUADRANT1) begin
      bad = 1'b1;
    end else begin
      case (funct3)
        C3_ADDI: word = {imm6, rd, F3_ADD, rd, OPC_OPIMM};
        C3_LI:   word = {imm6, REG_ZERO, F3_ADD, rd, OPC_OPIMM};
        C3_LUI: begin
          if (rd == REG_SP) begin
            word = {imm16sp, REG_SP, F3_ADD, REG_SP, OPC_OPIMM};
          end else begin
            word = {imm_lui, rd, OPC_LUI};
          end
        end
        C3_ALU: begin
          case (funct2)
            F2_SRLI, F2_SRAI: begin
              // A zero shift amount is reserved in RV32C.
              if (low5 == 5'd0) begin
                bad = 1'b1;
              end else begin
                word = {1'b0, (funct2 == F2_SRAI), 5'b00000, low5, rdp, F3_SR, rdp, OPC_OPIMM};
              end
            end
            F2_ANDI: word = {imm6, rdp, F3_AND, rdp, OPC_OPIMM};
            F2_REG: begin
              if (cinstr[12]) begin
                bad = 1'b1;
              end else begin
                case (sel)
                  SEL_SUB: word = {FUNCT7_ALT, rs2p, rdp, F3_ADD, rdp, OPC_OP};
                  SEL_XOR: word = {FUNCT7_STD, rs2p, rdp, F3_XOR, rdp, OPC_OP};
                  SEL_OR:  word = {FUNCT7_STD, rs2p, rdp, F3_OR,  rdp, OPC_OP};
                  SEL_AND: word = {FUNCT7_STD, rs2p, rdp, F3_AND, rdp, OPC_OP};
                  default: bad = 1'b1;
                endcase
              end
            end
            default: bad = 1'b1;
          endcase
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      word = '0;
    end
  end

  assign result.word    = word;
  assign result.illegal = bad;

endmodule

FILE: sv/rvc_quadrant1_expander.sv
// Top level of the RV32C quadrant-1 expander: input register, decoder, result register.
// Depends on rvcq1_pkg and rvcq1_decoder.
`timescale 1ns / 1ps

// One compressed halfword is taken at each rising edge at which start is high;
// busy is always low, so a transfer can happen every cycle. The expanded word
// and the illegal flag appear with done once the input register and then the
// result register (loaded through the decoder) have taken the halfword, so
// results follow back to back at one per cycle. They stay for one cycle only:
// the receiver must take them then. Illegal encodings give an expanded word of
// zero.
module rvc_quadrant1_expander import rvcq1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] cinstr,
  output logic        done,
  output logic [31:0] expanded_word,
  output logic        illegal
);

  logic           in_valid;
  logic [15:0]    in_word;
  expand_result_t decoded;
  logic           out_valid;
  expand_result_t out_result;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= start && !busy;
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    in_word    <= cinstr;
    out_result <= decoded;
  end

  rvcq1_decoder u_decoder (
    .cinstr (in_word),
    .result (decoded)
  );

  assign done          = out_valid;
  assign expanded_word = out_result.word;
  assign illegal       = out_result.illegal;

  // Every result comes from an earlier transfer, through the input and result registers.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 2))
    else $error("done without a transfer two cycles earlier");

  // An illegal result carries a zero word.
  assert property (@(posedge clk) disable iff (rst) (done && illegal) |-> expanded_word == 32'd0)
    else $error("illegal result with a nonzero word");

  // A legal result is always a full 32-bit encoding.
  assert property (@(posedge clk) disable iff (rst)
                   (done && !illegal) |-> expanded_word[1:0] == 2'b11)
    else $error("legal result without a 32-bit opcode");

  // A halfword outside quadrant 1 is always flagged.
  assert property (@(posedge clk) disable iff (rst)
                   (done && $past(cinstr[1:0], 2) != QUADRANT1) |-> illegal)
    else $error("wrong quadrant not flagged");

endmodule

FILE: tb/sv/tb_rvc_quadrant1_expander.sv
// Self-checking testbench for rvc_quadrant1_expander: a directed table, then random halfwords.
// Every expansion is predicted here and compared field by field. Depends on rvcq1_pkg.
`timescale 1ns / 1ps

module tb_rvc_quadrant1_expander;
  import rvcq1_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_PER_PHASE = 245;
  localparam int NUM_ROWS = 25;

  typedef struct packed {
    logic [15:0] halfword;
    logic        typed;
    logic [31:0] word;
    logic        illegal;
  } stim_row_t;

  typedef struct packed {
    logic [15:0]    halfword;
    expand_result_t result;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] cinstr = '0;
  logic        busy;
  logic        done;
  logic [31:0] expanded_word;
  logic        illegal;

  pending_t pending_expansions[$];
  int       errors = 0;
  int       halfwords_sent = 0;
  int       results_checked = 0;
  int       illegal_seen = 0;
  int       idle_cycles = 0;
  int       max_gap = 14;

  // Rows marked typed carry an expectation written out by hand; the rest use the predictor.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{16'h0001, 1'b1, 32'h0000_0013, 1'b0},  // canonical nop
    '{16'h0000, 1'b1, 32'h0000_0000, 1'b1},  // quadrant 0
    '{16'hFFFF, 1'b1, 32'h0000_0000, 1'b1},  // quadrant 3
    '{16'h2001, 1'b1, 32'h0000_0000, 1'b1},  // C.JAL, not expanded here
    '{16'hA001, 1'b1, 32'h0000_0000, 1'b1},  // C.J
    '{16'hC001, 1'b1, 32'h0000_0000, 1'b1},  // C.BEQZ
    '{16'hE001, 1'b1, 32'h0000_0000, 1'b1},  // C.BNEZ
    '{16'h9C01, 1'b1, 32'h0000_0000, 1'b1},  // reserved register-register group
    '{16'h8001, 1'b1, 32'h0000_0000, 1'b1},  // C.SRLI with zero shift
    '{16'h8401, 1'b1, 32'h0000_0000, 1'b1},  // C.SRAI with zero shift
    '{16'h9001, 1'b1, 32'h0000_0000, 1'b1},  // zero shift, bit 12 set
    '{16'h6101, 1'b1, 32'h0001_0113, 1'b0},  // C.ADDI16SP with zero immediate
    '{16'h6001, 1'b1, 32'h0000_0037, 1'b0},  // C.LUI x0 with zero immediate
    '{16'h1FFD, 1'b0, 32'h0, 1'b0},          // C.ADDI x31, -1
    '{16'h407D, 1'b0, 32'h0, 1'b0},          // C.LI x0, 31
    '{16'h7101, 1'b0, 32'h0, 1'b0},          // C.ADDI16SP -512
    '{16'h617D, 1'b0, 32'h0, 1'b0},          // C.ADDI16SP 496
    '{16'h7FFD, 1'b0, 32'h0, 1'b0},          // C.LUI x31, all ones
    '{16'h83FD, 1'b0, 32'h0, 1'b0},          // C.SRLI x15, 31
    '{16'h9405, 1'b0, 32'h0, 1'b0},          // C.SRAI x8, 1 with bit 12 set
    '{16'h9801, 1'b0, 32'h0, 1'b0},          // C.ANDI x8, -32
    '{16'h8C1D, 1'b0, 32'h0, 1'b0},          // C.SUB
    '{16'h8C21, 1'b0, 32'h0, 1'b0},          // C.XOR
    '{16'h8C41, 1'b0, 32'h0, 1'b0},          // C.OR
    '{16'h8FE1, 1'b0, 32'h0, 1'b0}           // C.AND x15, x8
  };

  rvc_quadrant1_expander u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cinstr         (cinstr),
    .done           (done),
    .expanded_word  (expanded_word),
    .illegal        (illegal)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic expand_result_t expand_halfword(input logic [15:0] hw);
    expand_result_t r;
    logic [4:0]  rd;
    logic [4:0]  rdp;
    logic [4:0]  rs2p;
    logic [11:0] imm6;
    logic [11:0] sp_imm;
    logic [19:0] upper;
    rd     = hw[11:7];
    rdp    = {2'b01, hw[9:7]};
    rs2p   = {2'b01, hw[4:2]};
    imm6   = {{7{hw[12]}}, hw[6:2]};
    sp_imm = {{3{hw[12]}}, hw[4:3], hw[5], hw[2], hw[6], 4'b0000};
    upper  = {{15{hw[12]}}, hw[6:2]};
    r.word    = '0;
    r.illegal = 1'b0;
    if (hw[1:0] != QUADRANT1) begin
      r.illegal = 1'b1;
    end else begin
      case (hw[15:13])
        C3_ADDI: r.word = {imm6, rd, F3_ADD, rd, OPC_OPIMM};
        C3_LI:   r.word = {imm6, REG_ZERO, F3_ADD, rd, OPC_OPIMM};
        C3_LUI: begin
          if (rd == REG_SP) r.word = {sp_imm, REG_SP, F3_ADD, REG_SP, OPC_OPIMM};
          else r.word = {upper, rd, OPC_LUI};
        end
        C3_ALU: begin
          case (hw[11:10])
            F2_SRLI, F2_SRAI: begin
              if (hw[6:2] == 5'd0) begin
                r.illegal = 1'b1;
              end else begin
                r.word = {(hw[11:10] == F2_SRAI) ? FUNCT7_ALT : FUNCT7_STD,
                          hw[6:2], rdp, F3_SR, rdp, OPC_OPIMM};
              end
            end
            F2_ANDI: r.word = {imm6, rdp, F3_AND, rdp, OPC_OPIMM};
            default: begin
              if (hw[12]) begin
                r.illegal = 1'b1;
              end else begin
                case (hw[6:5])
                  SEL_SUB: r.word = {FUNCT7_ALT, rs2p, rdp, F3_ADD, rdp, OPC_OP};
                  SEL_XOR: r.word = {FUNCT7_STD, rs2p, rdp, F3_XOR, rdp, OPC_OP};
                  SEL_OR:  r.word = {FUNCT7_STD, rs2p, rdp, F3_OR, rdp, OPC_OP};
                  default: r.word = {FUNCT7_STD, rs2p, rdp, F3_AND, rdp, OPC_OP};
                endcase
              end
            end
          endcase
        end
        default: r.illegal = 1'b1;
      endcase
    end
    if (r.illegal) r.word = '0;
    return r;
  endfunction

  // Presents one halfword after a random gap and returns at the edge of its transfer.
  task automatic send_halfword(input logic [15:0] hw, input logic typed,
                               input expand_result_t typed_result);
    int       gap;
    pending_t entry;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cinstr <= hw;
    do @(posedge clk); while (busy);
    entry.halfword = hw;
    entry.result   = typed ? typed_result : expand_halfword(hw);
    pending_expansions.push_back(entry);
    halfwords_sent++;
  endtask

  task automatic drain_pending();
    start <= 1'b0;
    while (pending_expansions.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    pending_t entry;
    if (!rst && done) begin
      if (pending_expansions.size() == 0) begin
        $display("%0t: result with nothing expected: expanded_word %h illegal %b",
                 $time, expanded_word, illegal);
        errors++;
      end else begin
        entry = pending_expansions.pop_front();
        results_checked++;
        if (illegal) illegal_seen++;
        if (expanded_word !== entry.result.word) begin
          $display("%0t: halfword %h expanded_word expected %h actual %h",
                   $time, entry.halfword, entry.result.word, expanded_word);
          errors++;
        end
        if (illegal !== entry.result.illegal) begin
          $display("%0t: halfword %h illegal expected %b actual %b",
                   $time, entry.halfword, entry.result.illegal, illegal);
          errors++;
        end
      end
    end
  end

  // Counts cycles with neither an input transfer nor a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("rvc_quadrant1_expander verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int             idx;
    int             phase;
    logic [15:0]    hw;
    expand_result_t typed_result;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (idx = 0; idx < NUM_ROWS; idx++) begin
      typed_result.word    = directed_rows[idx].word;
      typed_result.illegal = directed_rows[idx].illegal;
      send_halfword(directed_rows[idx].halfword, directed_rows[idx].typed, typed_result);
    end
    drain_pending();

    // Phase 1 has long gaps, phase 2 is back to back, phase 3 has short gaps.
    for (phase = 0; phase < 3; phase++) begin
      max_gap = (phase == 0) ? 14 : (phase == 1) ? 0 : 3;
      for (idx = 0; idx < RANDOM_PER_PHASE; idx++) begin
        hw = 16'($urandom);
        // Mostly quadrant 1, and mostly the funct3 values that expand.
        if ($urandom_range(0, 99) < 85) begin
          hw[1:0] = QUADRANT1;
          if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 3))
              0: hw[15:13] = C3_ADDI;
              1: hw[15:13] = C3_LI;
              2: hw[15:13] = C3_LUI;
              default: hw[15:13] = C3_ALU;
            endcase
          end
        end
        send_halfword(hw, 1'b0, '0);
      end
      drain_pending();
    end

    repeat (6) @(posedge clk);
    if (pending_expansions.size() != 0) begin
      $display("%0t: %0d expansions never arrived", $time, pending_expansions.size());
      errors++;
    end
    $display("Sent %0d halfwords (%0d from the directed table); checked %0d results, %0d illegal.",
             halfwords_sent, NUM_ROWS, results_checked, illegal_seen);
    $display("Sender gaps ranged from none to 14 cycles; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("rvc_quadrant1_expander verification clean");
    end else begin
      $display("rvc_quadrant1_expander verification failed");
    end
    $finish;
  end

endmodule
